@@ sv/bti_pkg.sv @@
`timescale 1ns / 1ps
// bti_pkg: beat types, register indexes and reset values of the bilinear table interpolator
// no dependencies; imported by bilinear_table_interpolator

package bti_pkg;

  // default table size, rows by columns
  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_SCALE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_ROWS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_COLS  = 3'd5;

  // register reset values
  localparam logic signed [23:0] DENSITY_MIN_RST       = -24'sd524288;
  localparam logic signed [23:0] TEMPERATURE_MIN_RST   = 24'sd65536;
  localparam logic [23:0]        DENSITY_SCALE_RST     = 24'd1086805;
  localparam logic [23:0]        TEMPERATURE_SCALE_RST = 24'd1630208;
  localparam logic [8:0]         DENSITY_ROWS_RST      = 9'd200;
  localparam logic [8:0]         TEMPERATURE_COLS_RST  = 9'd200;

  // item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] rate_value;
    logic signed [31:0] fraction_value;
    logic signed [23:0] log_temp;
    logic signed [23:0] log_density;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rate;
    logic signed [31:0] electron_fraction;
    logic               saturated;
  } out_item_t;

endpackage

@@ sv/bti_ram.sv @@
`timescale 1ns / 1ps
// bti_ram: generic simple dual-port RAM, one write port, one registered read port
// no dependencies; used for the table banks of bilinear_table_interpolator

module bti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bilinear_table_interpolator.sv @@
`timescale 1ns / 1ps
// bilinear_table_interpolator: pipelined 2-D bilinear lookup over a rate and a fraction table
// depends on bti_pkg (types, register indexes, reset values) and bti_ram (table banks)
//
//  port group  dir   handshake              payload
//  in_         in    in_valid / in_stall    in_item_t: table write or lookup
//  out_        out   out_valid / out_stall  out_item_t: rate, electron_fraction, saturated
//  cfg_        in    cfg_valid / cfg_ready  cfg_index, cfg_data (24 bit)
//
// one item per cycle sustained while out_stall is low; a lookup reaches out_valid past all stages
// the tables sit in four row/column parity banks, each with one read port, so the four
// corner entries of a lookup come out in one cycle; a write beat updates its bank at the
// same stage where lookups read, which keeps table order with the item stream
// rst_n (synchronous) clears valids and resets config registers; tables are undefined until written
// out_stall holds only the stages that are full; in_stall rises when the first stage is full and blocked

module bilinear_table_interpolator
  import bti_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // sizes
  localparam int RW         = $clog2(MAX_ROWS);
  localparam int CW         = $clog2(MAX_COLS);
  localparam int HR         = (MAX_ROWS + 1) / 2;
  localparam int HC         = (MAX_COLS + 1) / 2;
  localparam int BANK_DEPTH = HR * HC;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int AFW        = 20;
  localparam int IXW        = 11;
  localparam int NS         = 11;
  localparam int WORD_W     = 64;
  localparam int DIFW       = 25;
  localparam int PW         = 50;
  localparam int XW         = 33;
  localparam int EW         = 32;
  localparam int DW         = 33;
  localparam int PPW        = 50;
  localparam int AW         = 67;
  localparam int DDW        = 68;
  localparam int MW         = 56;
  localparam int M2W        = 57;
  localparam int SW         = 102;
  localparam logic signed [SW-1:0] ROUND_HALF = {{(SW-32){1'b0}}, 32'h8000_0000};

  typedef logic signed [DIFW-1:0] diff_t;
  typedef logic signed [PW-1:0]   pos_t;
  typedef logic signed [XW-1:0]   frac_t;
  typedef logic signed [EW-1:0]   entry_t;
  typedef logic signed [DW-1:0]   delta_t;
  typedef logic signed [PPW-1:0]  pprod_t;
  typedef logic signed [AW-1:0]   blend_t;
  typedef logic signed [DDW-1:0]  span_t;
  typedef logic signed [MW-1:0]   mprod_t;
  typedef logic signed [M2W-1:0]  mprod_hi_t;
  typedef logic signed [SW-1:0]   sum_t;

  // configuration registers
  logic signed [23:0] density_min_r, temperature_min_r;
  logic [23:0]        density_scale_r, temperature_scale_r;
  logic [8:0]         density_rows_r, temperature_cols_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      density_min_r       <= DENSITY_MIN_RST;
      temperature_min_r   <= TEMPERATURE_MIN_RST;
      density_scale_r     <= DENSITY_SCALE_RST;
      temperature_scale_r <= TEMPERATURE_SCALE_RST;
      density_rows_r      <= DENSITY_ROWS_RST;
      temperature_cols_r  <= TEMPERATURE_COLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DENSITY_MIN:       density_min_r       <= cfg_data;
        CFG_TEMPERATURE_MIN:   temperature_min_r   <= cfg_data;
        CFG_DENSITY_SCALE:     density_scale_r     <= cfg_data;
        CFG_TEMPERATURE_SCALE: temperature_scale_r <= cfg_data;
        CFG_DENSITY_ROWS:      density_rows_r      <= cfg_data[8:0];
        CFG_TEMPERATURE_COLS:  temperature_cols_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // per-axis view of the registers: axis 0 density (rows), axis 1 temperature (columns)
  logic signed [23:0] axis_min   [2];
  logic [23:0]        axis_scale [2];
  logic [8:0]         axis_cnt   [2];
  logic [IXW-1:0]     axis_lim   [2];

  always_comb begin
    axis_min[0]   = density_min_r;
    axis_min[1]   = temperature_min_r;
    axis_scale[0] = density_scale_r;
    axis_scale[1] = temperature_scale_r;
    axis_cnt[0]   = density_rows_r;
    axis_cnt[1]   = temperature_cols_r;
    axis_lim[0]   = IXW'(MAX_ROWS);
    axis_lim[1]   = IXW'(MAX_COLS);
  end

  // pipeline flow control: a stage loads when empty or when the next one moves
  logic [NS+1:1] en;
  logic [NS:1]   v_r, v_nxt;
  logic          out_valid_r;
  logic          out_en;

  assign out_en     = !out_valid_r || !out_stall;
  assign en[NS+1]   = out_en;
  for (genvar k = 1; k <= NS; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign in_stall = !en[1];

  // stage registers
  in_item_t  s1_item_r, s2_item_r, s3_item_r;
  diff_t     s1_diff_r [2], s1_diff_nxt [2];
  pos_t      s2_p_r [2], s2_p_nxt [2];
  logic [RW-1:0] s3_row_r, s3_row_nxt;
  logic [CW-1:0] s3_col_r, s3_col_nxt;
  frac_t     s3_x_r [2], s3_x_nxt [2];
  frac_t     s4_x_r [2];
  logic      s4_rpar_r, s4_cpar_r;
  entry_t    s5_e0_r [2], s5_e1_r [2], s5_e0_nxt [2], s5_e1_nxt [2];
  delta_t    s5_d0_r [2], s5_d1_r [2], s5_d0_nxt [2], s5_d1_nxt [2];
  frac_t     s5_x_r [2];
  entry_t    s6_e0_r [2], s6_e1_r [2];
  pprod_t    s6_ph0_r [2], s6_pl0_r [2], s6_ph1_r [2], s6_pl1_r [2];
  pprod_t    s6_ph0_nxt [2], s6_pl0_nxt [2], s6_ph1_nxt [2], s6_pl1_nxt [2];
  frac_t     s6_x1_r;
  blend_t    s7_a_r [2], s7_b_r [2], s7_a_nxt [2], s7_b_nxt [2];
  frac_t     s7_x1_r;
  blend_t    s8_a_r [2];
  span_t     s8_d_r [2], s8_d_nxt [2];
  frac_t     s8_x1_r;
  blend_t    s9_a_r [2];
  mprod_t    s9_m0_r [2], s9_m1_r [2], s9_m0_nxt [2], s9_m1_nxt [2];
  mprod_hi_t s9_m2_r [2], s9_m2_nxt [2];
  sum_t      s10_t1_r [2], s10_t2_r [2], s10_t1_nxt [2], s10_t2_nxt [2];
  sum_t      s11_v_r [2], s11_v_nxt [2];
  out_item_t out_data_r, out_data_nxt;

  // table banks, indexed by row parity then column parity
  logic             bank_we    [2][2];
  logic [BAW-1:0]   bank_raddr [2][2];
  logic [WORD_W-1:0] bank_rd   [2][2];
  logic [BAW-1:0]   bank_waddr;
  logic [WORD_W-1:0] bank_wdata;

  // valid bits; write beats leave the pipe once their bank write is done
  always_comb begin
    v_nxt[1] = in_valid;
    for (int k = 2; k <= NS; k++) begin
      v_nxt[k] = v_r[k-1];
    end
    v_nxt[4] = v_r[3] && (s3_item_r.kind == KIND_LOOKUP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
      if (out_en) begin
        out_valid_r <= v_r[NS];
      end
    end
  end

  // stage 1: offset from axis minimum
  always_comb begin
    s1_diff_nxt[0] = DIFW'(in_data.log_density) - DIFW'(axis_min[0]);
    s1_diff_nxt[1] = DIFW'(in_data.log_temp) - DIFW'(axis_min[1]);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_item_r <= in_data;
      s1_diff_r <= s1_diff_nxt;
    end
  end

  // stage 2: grid position with 32 fraction bits
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s2_p_nxt[a] = PW'(s1_diff_r[a]) * PW'($signed({1'b0, axis_scale[a]}));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_item_r <= s1_item_r;
      s2_p_r    <= s2_p_nxt;
    end
  end

  // stage 3: clamped cell index and unclamped Q16 fraction
  always_comb begin
    logic [PW-33:0]  ipart;
    logic [IXW-1:0]  n;
    logic [IXW-1:0]  top;
    logic [IXW-1:0]  idx [2];
    logic [PW-17:0]  q;
    for (int a = 0; a < 2; a++) begin
      ipart = s2_p_r[a][PW-1:32];
      n = {2'b00, axis_cnt[a]};
      if (n < IXW'(2)) begin
        n = IXW'(2);
      end
      if (n > axis_lim[a]) begin
        n = axis_lim[a];
      end
      top = n - IXW'(2);
      if (s2_p_r[a][PW-1]) begin
        idx[a] = '0;
      end else if (ipart > {{(PW-32-IXW){1'b0}}, top}) begin
        idx[a] = top;
      end else begin
        idx[a] = ipart[IXW-1:0];
      end
      q = s2_p_r[a][PW-1:16] - {{(PW-32-IXW){1'b0}}, idx[a], 16'b0};
      s3_x_nxt[a] = q[XW-1:0];
    end
    s3_row_nxt = idx[0][RW-1:0];
    s3_col_nxt = idx[1][CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_item_r <= s2_item_r;
      s3_row_r  <= s3_row_nxt;
      s3_col_r  <= s3_col_nxt;
      s3_x_r    <= s3_x_nxt;
    end
  end

  // bank addressing: row r and r+1 sit in opposite parity banks, same for columns
  always_comb begin
    logic [RW:0]      half_r [2];
    logic [CW:0]      half_c [2];
    logic [AFW-1:0]   rfull;
    logic [AFW-1:0]   wfull;
    logic             wr_ok;
    half_r[0] = ({1'b0, s3_row_r} + (RW+1)'(1)) >> 1;
    half_r[1] = {1'b0, s3_row_r} >> 1;
    half_c[0] = ({1'b0, s3_col_r} + (CW+1)'(1)) >> 1;
    half_c[1] = {1'b0, s3_col_r} >> 1;
    for (int rp = 0; rp < 2; rp++) begin
      for (int cp = 0; cp < 2; cp++) begin
        rfull = AFW'(half_r[rp]) * AFW'(HC) + AFW'(half_c[cp]);
        bank_raddr[rp][cp] = rfull[BAW-1:0];
      end
    end
    // write beat: one bank, entries outside the table dropped
    wfull = AFW'(s3_item_r.row[7:1]) * AFW'(HC) + AFW'(s3_item_r.col[7:1]);
    bank_waddr = wfull[BAW-1:0];
    bank_wdata = {s3_item_r.rate_value, s3_item_r.fraction_value};
    wr_ok = en[4] && v_r[3] && (s3_item_r.kind == KIND_WRITE)
            && ({3'b000, s3_item_r.row} < IXW'(MAX_ROWS))
            && ({3'b000, s3_item_r.col} < IXW'(MAX_COLS));
    for (int rp = 0; rp < 2; rp++) begin
      for (int cp = 0; cp < 2; cp++) begin
        bank_we[rp][cp] = wr_ok && (s3_item_r.row[0] == 1'(rp))
                          && (s3_item_r.col[0] == 1'(cp));
      end
    end
  end

  // stage 4: bank read data registers, fractions and parities alongside
  for (genvar rp = 0; rp < 2; rp++) begin : g_row_bank
    for (genvar cp = 0; cp < 2; cp++) begin : g_col_bank
      bti_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK_DEPTH)
      ) u_bank (
        .clk   (clk),
        .we    (bank_we[rp][cp]),
        .waddr (bank_waddr),
        .wdata (bank_wdata),
        .re    (en[4]),
        .raddr (bank_raddr[rp][cp]),
        .rdata (bank_rd[rp][cp])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_x_r    <= s3_x_r;
      s4_rpar_r <= s3_row_r[0];
      s4_cpar_r <= s3_col_r[0];
    end
  end

  // stage 5: pick the four corners, differences along the column axis
  always_comb begin
    logic [WORD_W-1:0] w00, w01, w10, w11;
    entry_t            e00, e01, e10, e11;
    w00 = bank_rd[s4_rpar_r][s4_cpar_r];
    w01 = bank_rd[s4_rpar_r][~s4_cpar_r];
    w10 = bank_rd[~s4_rpar_r][s4_cpar_r];
    w11 = bank_rd[~s4_rpar_r][~s4_cpar_r];
    for (int t = 0; t < 2; t++) begin
      e00 = $signed(w00[(1-t)*EW +: EW]);
      e01 = $signed(w01[(1-t)*EW +: EW]);
      e10 = $signed(w10[(1-t)*EW +: EW]);
      e11 = $signed(w11[(1-t)*EW +: EW]);
      s5_e0_nxt[t] = e00;
      s5_e1_nxt[t] = e10;
      s5_d0_nxt[t] = DW'(e01) - DW'(e00);
      s5_d1_nxt[t] = DW'(e11) - DW'(e10);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_e0_r <= s5_e0_nxt;
      s5_e1_r <= s5_e1_nxt;
      s5_d0_r <= s5_d0_nxt;
      s5_d1_r <= s5_d1_nxt;
      s5_x_r  <= s4_x_r;
    end
  end

  // stage 6: column fraction times differences, split into high and low halves
  always_comb begin
    logic signed [16:0] xh, xl;
    xh = $signed(s5_x_r[1][XW-1:16]);
    xl = $signed({1'b0, s5_x_r[1][15:0]});
    for (int t = 0; t < 2; t++) begin
      s6_ph0_nxt[t] = PPW'(xh) * PPW'(s5_d0_r[t]);
      s6_pl0_nxt[t] = PPW'(xl) * PPW'(s5_d0_r[t]);
      s6_ph1_nxt[t] = PPW'(xh) * PPW'(s5_d1_r[t]);
      s6_pl1_nxt[t] = PPW'(xl) * PPW'(s5_d1_r[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_e0_r  <= s5_e0_r;
      s6_e1_r  <= s5_e1_r;
      s6_ph0_r <= s6_ph0_nxt;
      s6_pl0_r <= s6_pl0_nxt;
      s6_ph1_r <= s6_ph1_nxt;
      s6_pl1_r <= s6_pl1_nxt;
      s6_x1_r  <= s5_x_r[0];
    end
  end

  // stage 7: row blends in Q16
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      s7_a_nxt[t] = ((AW'(s6_e0_r[t]) + AW'(s6_ph0_r[t])) <<< 16) + AW'(s6_pl0_r[t]);
      s7_b_nxt[t] = ((AW'(s6_e1_r[t]) + AW'(s6_ph1_r[t])) <<< 16) + AW'(s6_pl1_r[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_a_r  <= s7_a_nxt;
      s7_b_r  <= s7_b_nxt;
      s7_x1_r <= s6_x1_r;
    end
  end

  // stage 8: difference between the two row blends
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      s8_d_nxt[t] = DDW'(s7_b_r[t]) - DDW'(s7_a_r[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_a_r  <= s7_a_r;
      s8_d_r  <= s8_d_nxt;
      s8_x1_r <= s7_x1_r;
    end
  end

  // stage 9: row fraction times difference, two 22-bit slices and a 24-bit top slice
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      s9_m0_nxt[t] = MW'(s8_x1_r) * MW'($signed({1'b0, s8_d_r[t][21:0]}));
      s9_m1_nxt[t] = MW'(s8_x1_r) * MW'($signed({1'b0, s8_d_r[t][43:22]}));
      s9_m2_nxt[t] = M2W'(s8_x1_r) * M2W'($signed(s8_d_r[t][DDW-1:44]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_a_r  <= s8_a_r;
      s9_m0_r <= s9_m0_nxt;
      s9_m1_r <= s9_m1_nxt;
      s9_m2_r <= s9_m2_nxt;
    end
  end

  // stage 10: partial sums, rounding half folded in
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      s10_t1_nxt[t] = (SW'(s9_a_r[t]) <<< 16) + SW'(s9_m0_r[t]) + ROUND_HALF;
      s10_t2_nxt[t] = SW'(s9_m1_r[t]) + (SW'(s9_m2_r[t]) <<< 22);
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_t1_r <= s10_t1_nxt;
      s10_t2_r <= s10_t2_nxt;
    end
  end

  // stage 11: final Q32 sum
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      s11_v_nxt[t] = s10_t1_r[t] + (s10_t2_r[t] <<< 22);
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_v_r <= s11_v_nxt;
    end
  end

  // output register: integer part with saturation
  always_comb begin
    logic [SW-64:0]     hi;
    logic               fits;
    logic signed [31:0] res [2];
    logic               clip;
    clip = 1'b0;
    for (int t = 0; t < 2; t++) begin
      hi   = s11_v_r[t][SW-1:63];
      fits = (&hi) || !(|hi);
      if (fits) begin
        res[t] = s11_v_r[t][63:32];
      end else if (s11_v_r[t][SW-1]) begin
        res[t] = 32'sh8000_0000;
      end else begin
        res[t] = 32'sh7fff_ffff;
      end
      clip = clip || !fits;
    end
    out_data_nxt.rate              = res[0];
    out_data_nxt.electron_fraction = res[1];
    out_data_nxt.saturated         = clip;
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // lookup cell indexes always leave room for the upper neighbor
  a_index_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] && (s3_item_r.kind == KIND_LOOKUP) |->
      (s3_row_r <= RW'(MAX_ROWS - 2)) && (s3_col_r <= CW'(MAX_COLS - 2)))
    else $error("lookup index beyond last cell");

  // a clipped beat carries at least one limit value
  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.rate == 32'sh7fff_ffff) || (out_data.rate == 32'sh8000_0000) ||
      (out_data.electron_fraction == 32'sh7fff_ffff) ||
      (out_data.electron_fraction == 32'sh8000_0000))
    else $error("saturated flag without a limit value");

  // last stage keeps its beat while the output register is blocked
  a_last_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS] && out_valid_r && out_stall |=> v_r[NS])
    else $error("beat lost at the last stage");

  // input side only blocks when the first stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[1])
    else $error("input stalled into an empty pipe");

endmodule
